[rtl/core/mipsx_pkg.sv]
// Shared definitions for the MIPS32 integer-subset execute block.
// Opcode and function codes, controller states and the divider status struct.
// Used by mipsx_div and mips32_instruction_execute_top.
package mipsx_pkg;

    localparam int          DMEM_BYTES_DEF = 4096;
    localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
    localparam logic [31:0] SYSCALL_EXIT   = 32'd10;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE   = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDUI   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTUI   = 6'h0B;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the register-format opcode
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLTU    = 6'h29;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_RT,
        ST_EXEC,
        ST_MEM,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_res_t;

endpackage

[rtl/core/mipsx_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on mipsx_pkg for the result struct.
module mipsx_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         dividend,
    input  logic [31:0]         divisor,
    output mipsx_pkg::div_res_t res
);
    import mipsx_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

[rtl/core/mips32_instruction_execute_top.sv]
// MIPS32 integer-subset execute block: register file and byte data memory.
// Simple instructions pass through the register file read of rs, then rt, execute and commit;
// loads and stores add a memory phase that moves one byte at a time through the data memory;
// div and divu wait in the one-bit-per-cycle divider unless the divisor is zero or overflows.
// After reset the data memory is cleared byte by byte, and no transaction is accepted
// until the clear is done. The user must keep DMEM_BYTES a power of two; it is not checked.
module mips32_instruction_execute_top #(
    parameter int DMEM_BYTES = mipsx_pkg::DMEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: instruction[31:0], preload_address[43:32], preload_byte[51:44], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // s_tuser: mode[0]
    input  logic [0:0]  s_tuser,
    // m_tdata: next_pc[31:0], reg_written[32], dest_reg[37:33], dest_value[69:38],
    //          halted[70], fault[71]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mipsx_pkg::*;

    localparam int AW = $clog2(DMEM_BYTES);

    logic [31:0]   rf_mem [32];
    logic [7:0]    dm_mem [DMEM_BYTES];

    state_t        state_reg, state_next;
    logic [31:0]   pc_reg, pc_next;
    logic [31:0]   start_pc_reg, start_pc_next;
    logic          halt_reg, halt_next;
    logic [31:0]   hi_reg, hi_next;
    logic [31:0]   lo_reg, lo_next;
    logic [31:0]   vld_reg, vld_next;
    logic          mode_reg, mode_next;
    logic [31:0]   ins_reg, ins_next;
    logic [11:0]   pre_addr_reg, pre_addr_next;
    logic [7:0]    pre_byte_reg, pre_byte_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic          res_wr_reg, res_wr_next;
    logic [4:0]    res_dst_reg, res_dst_next;
    logic [31:0]   res_val_reg, res_val_next;
    logic [31:0]   res_npc_reg, res_npc_next;
    logic          res_halt_reg, res_halt_next;
    logic          res_fault_reg, res_fault_next;
    logic [31:0]   maddr_reg, maddr_next;
    logic [2:0]    mcnt_reg, mcnt_next;
    logic          mword_reg, mword_next;
    logic          mstore_reg, mstore_next;
    logic          msext_reg, msext_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;
    logic [71:0]   m_data_reg, m_data_next;

    logic [4:0]    rf_raddr, rf_raddr_reg;
    logic [31:0]   rf_rdata_reg;
    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [7:0]    dm_wdata, dm_rdata_reg;

    logic          div_start;
    logic [31:0]   div_a, div_b;
    div_res_t      div_res;

    logic          cfg_wr;
    logic          s_fire;
    logic [5:0]    op, fn;
    logic [4:0]    rs, rt, rd, sh;
    logic [31:0]   imm, se, boff, a, b, eaddr;
    logic [63:0]   prod;
    logic          wr;
    logic [4:0]    dst;
    logic [31:0]   val;
    logic [2:0]    mlast;
    logic [1:0]    mbyte;

    mipsx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .res      (div_res)
    );

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : start_pc_reg;
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Register file and data memory, both with registered read data.
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        rf_rdata_reg <= rf_mem[rf_raddr];
        rf_raddr_reg <= rf_raddr;
        if (dm_we) begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        dm_rdata_reg <= dm_mem[dm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            pc_reg       <= START_PC_RESET;
            start_pc_reg <= START_PC_RESET;
            halt_reg     <= 1'b0;
            hi_reg       <= '0;
            lo_reg       <= '0;
            vld_reg      <= '0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            start_pc_reg <= start_pc_next;
            halt_reg     <= halt_next;
            hi_reg       <= hi_next;
            lo_reg       <= lo_next;
            vld_reg      <= vld_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg      <= mode_next;
        ins_reg       <= ins_next;
        pre_addr_reg  <= pre_addr_next;
        pre_byte_reg  <= pre_byte_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_wr_reg    <= res_wr_next;
        res_dst_reg   <= res_dst_next;
        res_val_reg   <= res_val_next;
        res_npc_reg   <= res_npc_next;
        res_halt_reg  <= res_halt_next;
        res_fault_reg <= res_fault_next;
        maddr_reg     <= maddr_next;
        mcnt_reg      <= mcnt_next;
        mword_reg     <= mword_next;
        mstore_reg    <= mstore_next;
        msext_reg     <= msext_next;
        neg_q_reg     <= neg_q_next;
        neg_r_reg     <= neg_r_next;
        m_data_reg    <= m_data_next;
    end

    // Instruction fields of the held item
    assign op   = ins_reg[31:26];
    assign rs   = ins_reg[25:21];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign imm  = {16'd0, ins_reg[15:0]};
    assign se   = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign boff = {se[29:0], 2'b00};
    assign a    = a_reg;
    // An entry not yet written since reset reads as zero.
    assign b     = vld_reg[rf_raddr_reg] ? rf_rdata_reg : 32'd0;
    assign eaddr = a + se;
    assign prod  = {32'd0, a} * {32'd0, b};
    assign mlast = mstore_reg ? (mword_reg ? 3'd3 : 3'd0) : (mword_reg ? 3'd4 : 3'd1);
    // Byte lane of the read data that arrives in this cycle.
    assign mbyte = mcnt_reg[1:0] - 2'd1;

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        start_pc_next  = start_pc_reg;
        halt_next      = halt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        vld_next       = vld_reg;
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        ins_next       = ins_reg;
        pre_addr_next  = pre_addr_reg;
        pre_byte_next  = pre_byte_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_wr_next    = res_wr_reg;
        res_dst_next   = res_dst_reg;
        res_val_next   = res_val_reg;
        res_npc_next   = res_npc_reg;
        res_halt_next  = res_halt_reg;
        res_fault_next = res_fault_reg;
        maddr_next     = maddr_reg;
        mcnt_next      = mcnt_reg;
        mword_next     = mword_reg;
        mstore_next    = mstore_reg;
        msext_next     = msext_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        rf_raddr       = rt;
        rf_we          = 1'b0;
        rf_waddr       = res_dst_reg;
        rf_wdata       = res_val_reg;
        dm_we          = 1'b0;
        dm_waddr       = maddr_reg[AW-1:0] + AW'(mcnt_reg);
        dm_raddr       = maddr_reg[AW-1:0] + AW'(mcnt_reg);
        dm_wdata       = b_reg[7:0];
        div_start      = 1'b0;
        div_a          = a;
        div_b          = b;
        wr             = 1'b0;
        dst            = rd;
        val            = 32'd0;

        case (state_reg)
            ST_CLEAR: begin
                dm_we    = 1'b1;
                dm_waddr = clr_reg;
                dm_wdata = 8'd0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DMEM_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Syscall takes v0 through the rs read.
                if (s_tdata[31:26] == OP_RTYPE && s_tdata[5:0] == FN_SYSCALL) begin
                    rf_raddr = 5'd2;
                end else begin
                    rf_raddr = s_tdata[25:21];
                end
                if (s_fire) begin
                    mode_next     = s_tuser[0];
                    ins_next      = s_tdata[31:0];
                    pre_addr_next = s_tdata[43:32];
                    pre_byte_next = s_tdata[51:44];
                    state_next    = ST_READ_RT;
                end
            end
            ST_READ_RT: begin
                a_next     = vld_reg[rf_raddr_reg] ? rf_rdata_reg : 32'd0;
                rf_raddr   = rt;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                res_npc_next   = pc_reg + 32'd4;
                res_halt_next  = halt_reg;
                res_fault_next = 1'b0;
                state_next     = ST_DONE;
                if (halt_reg) begin
                    res_npc_next = pc_reg;
                end else if (mode_reg) begin
                    res_npc_next = pc_reg;
                    dm_we        = 1'b1;
                    dm_waddr     = AW'(pre_addr_reg);
                    dm_wdata     = pre_byte_reg;
                end else begin
                    case (op)
                        OP_RTYPE: begin
                            case (fn)
                                FN_ADD, FN_ADDU: begin wr = 1'b1; val = a + b; end
                                FN_SUB, FN_SUBU: begin wr = 1'b1; val = a - b; end
                                FN_AND: begin wr = 1'b1; val = a & b; end
                                FN_OR:  begin wr = 1'b1; val = a | b; end
                                FN_XOR: begin wr = 1'b1; val = a ^ b; end
                                FN_NOR: begin wr = 1'b1; val = ~(a | b); end
                                FN_SLT: begin
                                    wr  = 1'b1;
                                    val = {31'd0, $signed(a) < $signed(b)};
                                end
                                FN_SLTU: begin wr = 1'b1; val = {31'd0, a < b}; end
                                FN_SLL:  begin wr = 1'b1; val = b << sh; end
                                FN_SRL:  begin wr = 1'b1; val = b >> sh; end
                                FN_SRA:  begin wr = 1'b1; val = $unsigned($signed(b) >>> sh); end
                                FN_MFHI: begin wr = 1'b1; val = hi_reg; end
                                FN_MFLO: begin wr = 1'b1; val = lo_reg; end
                                FN_MTHI: hi_next = a;
                                FN_MULTU: begin
                                    hi_next = prod[63:32];
                                    lo_next = prod[31:0];
                                end
                                FN_DIVU, FN_DIV: begin
                                    if (b == 32'd0) begin
                                        res_fault_next = 1'b1;
                                        res_halt_next  = 1'b1;
                                    end else if (fn == FN_DIV && a == 32'h8000_0000
                                                 && b == 32'hFFFF_FFFF) begin
                                        lo_next = 32'h8000_0000;
                                        hi_next = 32'd0;
                                    end else begin
                                        div_start = 1'b1;
                                        if (fn == FN_DIV) begin
                                            div_a      = a[31] ? 32'd0 - a : a;
                                            div_b      = b[31] ? 32'd0 - b : b;
                                            neg_q_next = a[31] ^ b[31];
                                            neg_r_next = a[31];
                                        end else begin
                                            neg_q_next = 1'b0;
                                            neg_r_next = 1'b0;
                                        end
                                        state_next = ST_DIV;
                                    end
                                end
                                FN_SYSCALL: begin
                                    if (a == SYSCALL_EXIT) begin
                                        res_halt_next = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        OP_ADDI, OP_ADDUI: begin wr = 1'b1; dst = rt; val = a + se; end
                        OP_ORI:  begin wr = 1'b1; dst = rt; val = a | imm; end
                        OP_SLTI: begin
                            wr  = 1'b1;
                            dst = rt;
                            val = {31'd0, $signed(a) < $signed(se)};
                        end
                        OP_SLTUI: begin wr = 1'b1; dst = rt; val = {31'd0, a < se}; end
                        OP_LUI:   begin wr = 1'b1; dst = rt; val = {ins_reg[15:0], 16'd0}; end
                        OP_LB, OP_LBU, OP_LW, OP_SB, OP_SW: begin
                            wr          = (op == OP_LB || op == OP_LBU || op == OP_LW);
                            dst         = rt;
                            maddr_next  = eaddr;
                            mcnt_next   = 3'd0;
                            mword_next  = (op == OP_LW || op == OP_SW);
                            mstore_next = (op == OP_SB || op == OP_SW);
                            msext_next  = (op == OP_LB);
                            b_next      = b;
                            state_next  = ST_MEM;
                        end
                        OP_J: res_npc_next = pc_reg + {4'd0, ins_reg[25:0], 2'b00};
                        OP_BEQ: if (a == b) res_npc_next = pc_reg + boff;
                        OP_BNE: if (a != b) res_npc_next = pc_reg + boff;
                        OP_BGTZ: if ($signed(a) > 0) res_npc_next = pc_reg + boff;
                        OP_BLEZ: if (!($signed(a) > 0)) res_npc_next = pc_reg + 32'd4 + boff;
                        OP_REGIMM: if (!a[31]) res_npc_next = pc_reg + 32'd4 + boff;
                        default: ;
                    endcase
                end
                // A write to r0 is dropped and reported as no write.
                if (wr && dst == 5'd0) begin
                    wr = 1'b0;
                end
                res_wr_next  = wr;
                res_dst_next = wr ? dst : 5'd0;
                res_val_next = wr ? val : 32'd0;
            end
            ST_MEM: begin
                mcnt_next = mcnt_reg + 3'd1;
                if (mstore_reg) begin
                    dm_we    = 1'b1;
                    dm_wdata = b_reg[8*mcnt_reg[1:0] +: 8];
                end else if (mcnt_reg != 3'd0 && res_wr_reg) begin
                    // Read data of the byte issued in the previous cycle.
                    if (!mword_reg) begin
                        res_val_next = msext_reg ? {{24{dm_rdata_reg[7]}}, dm_rdata_reg}
                                                 : {24'd0, dm_rdata_reg};
                    end else begin
                        res_val_next[8*mbyte +: 8] = dm_rdata_reg;
                    end
                end
                if (mcnt_reg == mlast) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    lo_next    = neg_q_reg ? 32'd0 - div_res.quo : div_res.quo;
                    hi_next    = neg_r_reg ? 32'd0 - div_res.rem : div_res.rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_fault_reg, res_halt_reg, res_val_reg,
                                    res_dst_reg, res_wr_reg, res_npc_reg};
                    pc_next      = res_npc_reg;
                    halt_next    = res_halt_reg;
                    if (res_wr_reg) begin
                        rf_we              = 1'b1;
                        vld_next[res_dst_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_wr) begin
            start_pc_next = pwdata;
            pc_next       = pwdata;
        end
    end

endmodule
